### design/two_dim_histogram_binner_defines.svh
// Assertion macros for the two-dimensional histogram binner.
// Expects clk and rst in the scope where a macro is used.
`ifndef TWO_DIM_HISTOGRAM_BINNER_DEFINES_SVH
`define TWO_DIM_HISTOGRAM_BINNER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define THB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("histogram binner check failed");

// Next-cycle implication, off during reset.
`define THB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("histogram binner check failed");

`endif

### design/thb_pkg.sv
// Shared types and constants for the two-dimensional histogram binner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package thb_pkg;

  localparam int DEF_MAX_EDGES   = 7;
  localparam int DEF_COUNT_WIDTH = 32;

  localparam int VAL_W   = 32;
  localparam int BIN_W   = 3;
  localparam int ADDR_W  = 2 * BIN_W;
  localparam int CELLS   = 1 << ADDR_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [1:0] CMD_FILL  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EDGES_IN_USE = 3'd7;
  localparam logic [BIN_W-1:0] RESET_EDGES_IN_USE = 3'd7;

  // Classified request handed from front to back
  typedef struct packed {
    logic [1:0]       cmd;
    logic [BIN_W-1:0] col;
    logic [BIN_W-1:0] row;
    logic             err;
    logic [VAL_W-1:0] wdata;
  } thb_entry_t;

endpackage
`default_nettype wire

### design/two_dim_histogram_binner.sv
// Two-dimensional histogram binner with programmable bin edges.
// Input channel in_valid/in_stall carries one request per accept: cmd selects
// fill (bin x_value/y_value and bump that cell), read cell or write cell.
// Output channel out_valid/out_stall returns exactly one result per request,
// in order: bins or echoed indices, cell content, fill total, index error.
// Configuration: cfg_write with cfg_index 0..6 sets the signed Q16.16 edges,
// index 7 sets edges_in_use; write only while no request is in flight.
// Path: an accepted request passes the queue slot, then the request latch
// with its cell read, then the result register. The store takes the next request
// only after the last result registers, due to its single-port read-modify-write.
// A two-entry queue sits between binning and the store, so the input keeps
// taking requests while a result waits on a stalled receiver; once the queue
// fills, in_stall rises. A stalled result holds steady.
// Reset: all cells read as zero (per-cell valid flags), fill total zero, edges
// zero, edges_in_use seven; the block is ready as soon as reset is released.
// Depends on thb_pkg, thb_front, thb_queue and thb_back.
`timescale 1ns / 1ps
`default_nettype none
module two_dim_histogram_binner #(
  parameter int MAX_EDGES   = thb_pkg::DEF_MAX_EDGES,
  parameter int COUNT_WIDTH = thb_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [thb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [thb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        cmd,
  input  wire logic signed [thb_pkg::VAL_W-1:0]  x_value,
  input  wire logic signed [thb_pkg::VAL_W-1:0]  y_value,
  input  wire logic [thb_pkg::BIN_W-1:0]         col_index,
  input  wire logic [thb_pkg::BIN_W-1:0]         row_index,
  input  wire logic [thb_pkg::VAL_W-1:0]         write_count,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [thb_pkg::BIN_W-1:0]              col_bin,
  output logic [thb_pkg::BIN_W-1:0]              row_bin,
  output logic [thb_pkg::VAL_W-1:0]              cell_count,
  output logic [thb_pkg::VAL_W-1:0]              total_fills,
  output logic                                   index_error
);
  import thb_pkg::*;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_not_empty;
  thb_entry_t q_in;
  thb_entry_t q_head;

  thb_front #(
    .MAX_EDGES (MAX_EDGES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .x_value     (x_value),
    .y_value     (y_value),
    .col_index   (col_index),
    .row_index   (row_index),
    .write_count (write_count),
    .q_push      (q_push),
    .q_entry     (q_in),
    .q_full      (q_full)
  );

  thb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .not_empty  (q_not_empty)
  );

  thb_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .col_bin     (col_bin),
    .row_bin     (row_bin),
    .cell_count  (cell_count),
    .total_fills (total_fills),
    .index_error (index_error)
  );

endmodule
`default_nettype wire

### design/thb_front.sv
// Front end: holds the bin edge registers, bins fill samples and checks
// read/write indices. Depends on thb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module thb_front #(
  parameter int MAX_EDGES = thb_pkg::DEF_MAX_EDGES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [thb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [thb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      cmd,
  input  wire logic signed [thb_pkg::VAL_W-1:0] x_value,
  input  wire logic signed [thb_pkg::VAL_W-1:0] y_value,
  input  wire logic [thb_pkg::BIN_W-1:0]       col_index,
  input  wire logic [thb_pkg::BIN_W-1:0]       row_index,
  input  wire logic [thb_pkg::VAL_W-1:0]       write_count,
  output logic                                 q_push,
  output thb_pkg::thb_entry_t                  q_entry,
  input  wire logic                            q_full
);
  import thb_pkg::*;

  logic signed [VAL_W-1:0] edge_reg [MAX_EDGES];
  logic [BIN_W-1:0]        edges_in_use;
  logic [BIN_W-1:0]        n_use;
  logic [BIN_W:0]          dim;
  logic [BIN_W-1:0]        x_bin;
  logic [BIN_W-1:0]        y_bin;
  logic                    idx_bad;

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_edge
    always_ff @(posedge clk) begin
      if (rst) begin
        edge_reg[i] <= '0;
      end else if (cfg_write && cfg_index == CFG_IDX_W'(i)) begin
        edge_reg[i] <= VAL_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edges_in_use <= RESET_EDGES_IN_USE;
    end else if (cfg_write && cfg_index == REG_EDGES_IN_USE) begin
      edges_in_use <= cfg_data[BIN_W-1:0];
    end
  end

  // Clamp the edge count into 1 .. MAX_EDGES
  always_comb begin
    if (edges_in_use == '0) begin
      n_use = BIN_W'(1);
    end else if (edges_in_use > BIN_W'(MAX_EDGES)) begin
      n_use = BIN_W'(MAX_EDGES);
    end else begin
      n_use = edges_in_use;
    end
    dim = {1'b0, n_use} + (BIN_W+1)'(1);
  end

  // Bin = number of active edges at or below the sample
  function automatic logic [BIN_W-1:0] bin_of(input logic signed [VAL_W-1:0] v,
                                              input logic [BIN_W-1:0] n);
    logic [BIN_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < MAX_EDGES; i++) begin
      if (BIN_W'(i) < n && edge_reg[i] <= v) begin
        cnt = cnt + BIN_W'(1);
      end
    end
    return cnt;
  endfunction

  always_comb begin
    x_bin   = bin_of(x_value, n_use);
    y_bin   = bin_of(y_value, n_use);
    idx_bad = ({1'b0, col_index} >= dim) || ({1'b0, row_index} >= dim);
  end

  always_comb begin
    q_entry.cmd   = cmd;
    q_entry.wdata = write_count;
    case (cmd)
      CMD_FILL: begin
        q_entry.col = x_bin;
        q_entry.row = y_bin;
        q_entry.err = 1'b0;
      end
      CMD_READ, CMD_WRITE: begin
        q_entry.col = col_index;
        q_entry.row = row_index;
        q_entry.err = idx_bad;
      end
      default: begin
        q_entry.col = '0;
        q_entry.row = '0;
        q_entry.err = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule
`default_nettype wire

### design/thb_queue.sv
// Short request queue between the front end and the cell store.
// Depends on thb_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
module thb_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  thb_pkg::thb_entry_t      push_entry,
  output logic                     full,
  input  wire logic                pop,
  output thb_pkg::thb_entry_t      head,
  output logic                     not_empty
);
  import thb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  thb_entry_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  // Depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head      = slots[rd_ptr];
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);

endmodule
`default_nettype wire

### design/thb_back.sv
// Back end: read-modify-write of the cell store, fill total and result register.
// Depends on thb_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "two_dim_histogram_binner_defines.svh"
module thb_back #(
  parameter int COUNT_WIDTH = thb_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  thb_pkg::thb_entry_t               q_head,
  input  wire logic                         q_not_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [thb_pkg::BIN_W-1:0]         col_bin,
  output logic [thb_pkg::BIN_W-1:0]         row_bin,
  output logic [thb_pkg::VAL_W-1:0]         cell_count,
  output logic [thb_pkg::VAL_W-1:0]         total_fills,
  output logic                              index_error
);
  import thb_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   state;
  logic                   state_next;
  thb_entry_t             op;
  logic [ADDR_W-1:0]      op_addr;
  logic [COUNT_WIDTH-1:0] cells [CELLS];
  logic [CELLS-1:0]       cell_valid;
  logic [COUNT_WIDTH-1:0] rdata;
  logic                   rdata_valid;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] new_val;
  logic [COUNT_WIDTH-1:0] res_val;
  logic                   mem_we;
  logic [COUNT_WIDTH-1:0] fill_total;
  logic [COUNT_WIDTH-1:0] fill_total_next;
  logic                   out_free;
  logic                   advance;

  assign op_addr  = {op.col, op.row};
  assign out_free = !out_valid || !out_stall;
  assign advance  = (state == S_EXEC) && out_free;
  assign q_pop    = (state == S_IDLE) && q_not_empty;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (q_not_empty) state_next = S_EXEC;
      S_EXEC:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Latch the request and read its cell at the same edge
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op          <= q_head;
      rdata       <= cells[{q_head.col, q_head.row}];
      rdata_valid <= cell_valid[{q_head.col, q_head.row}];
    end
  end

  always_comb begin
    cur             = rdata_valid ? rdata : '0;
    new_val         = cur;
    res_val         = '0;
    mem_we          = 1'b0;
    fill_total_next = fill_total;
    case (op.cmd)
      CMD_FILL: begin
        if (cur != COUNT_MAX) new_val = cur + COUNT_WIDTH'(1);
        if (fill_total != COUNT_MAX) fill_total_next = fill_total + COUNT_WIDTH'(1);
        mem_we  = advance;
        res_val = new_val;
      end
      CMD_READ: begin
        if (!op.err) res_val = cur;
      end
      CMD_WRITE: begin
        if (!op.err) begin
          new_val = COUNT_WIDTH'(op.wdata);
          mem_we  = advance;
          res_val = new_val;
        end
      end
      default: begin
        res_val = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[op_addr] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cell_valid <= '0;
      fill_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_we) begin
        cell_valid[op_addr] <= 1'b1;
      end
      if (advance) begin
        fill_total <= fill_total_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      col_bin     <= (op.cmd == CMD_FILL || op.cmd == CMD_READ || op.cmd == CMD_WRITE)
                     ? op.col : '0;
      row_bin     <= (op.cmd == CMD_FILL || op.cmd == CMD_READ || op.cmd == CMD_WRITE)
                     ? op.row : '0;
      cell_count  <= VAL_W'(res_val);
      total_fills <= VAL_W'(fill_total_next);
      index_error <= op.err;
    end
  end

  `THB_ASSERT_IMP(a_we_in_exec, mem_we, state == S_EXEC && out_free)
  `THB_ASSERT_IMP(a_err_no_write, mem_we, !op.err)
  `THB_ASSERT_IMP(a_total_monotone, !$past(rst), fill_total >= $past(fill_total))
  `THB_ASSERT_NEXT(a_pop_then_exec, q_pop, state == S_EXEC)

endmodule
`default_nettype wire
